// ===== rtl/core/tlt_pkg.sv =====
package tlt_pkg;

    localparam int COORD_W = 24;
    localparam int WIDTH_W = 16;
    localparam int COLOR_W = 32;
    localparam int DIFF_W  = 25;
    localparam int MAG_W   = 24;
    // Fraction bits of the coordinates, also the scale of the width product.
    localparam int COORD_FRAC_BITS = 8;
    // Squared length shifted left by 14: 49 + 14 bits.
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 31;
    localparam int NUM_W   = 61;

    localparam logic signed [COORD_W:0] COORD_MAX = 25'sd8388607;
    localparam logic signed [COORD_W:0] COORD_MIN = -25'sd8388608;

    // Segment record passed from the front end to the back end.
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [WIDTH_W-1:0]        w;
        logic [MAG_W-1:0]          adx;
        logic [MAG_W-1:0]          ady;
        logic                      dx_neg;
        logic                      dy_neg;
    } seg_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W+1:0] v
    );
        logic signed [COORD_W-1:0] r;
        begin
            if (v > 26'(COORD_MAX))
                r = COORD_MAX[COORD_W-1:0];
            else if (v < 26'(COORD_MIN))
                r = COORD_MIN[COORD_W-1:0];
            else
                r = v[COORD_W-1:0];
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/tlt_front.sv =====
module tlt_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [tlt_pkg::COORD_W-1:0] start_x,
    input  logic signed [tlt_pkg::COORD_W-1:0] start_y,
    input  logic signed [tlt_pkg::COORD_W-1:0] end_x,
    input  logic signed [tlt_pkg::COORD_W-1:0] end_y,
    input  logic [tlt_pkg::WIDTH_W-1:0]        line_width,
    output logic                               q_push,
    output tlt_pkg::seg_t                      q_data,
    input  logic                               q_full
);
    import tlt_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    seg_t                     seg_reg;
    logic                     acc;

    // One stage: differences and signs, zero length segments dropped.
    assign busy = out_valid_reg && q_full;
    assign acc  = start && !busy;
    assign dx   = DIFF_W'(end_x) - DIFF_W'(start_x);
    assign dy   = DIFF_W'(end_y) - DIFF_W'(start_y);

    always_comb
    begin
        out_valid_next = out_valid_reg && !(q_push);
        if (acc)
            out_valid_next = (dx != '0) || (dy != '0);
    end

    assign q_push = out_valid_reg && !q_full;
    assign q_data = seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            seg_reg.x1     <= start_x;
            seg_reg.y1     <= start_y;
            seg_reg.x2     <= end_x;
            seg_reg.y2     <= end_y;
            seg_reg.w      <= line_width;
            seg_reg.adx    <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            seg_reg.ady    <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            seg_reg.dx_neg <= dx[DIFF_W-1];
            seg_reg.dy_neg <= dy[DIFF_W-1];
        end
    end

endmodule

// ===== rtl/core/tlt_queue.sv =====
module tlt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tlt_pkg::seg_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output tlt_pkg::seg_t rdata
);
    import tlt_pkg::*;

    // Two entry queue between front and back end.
    seg_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rdata     = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

// ===== rtl/core/tlt_back.sv =====
module tlt_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  tlt_pkg::seg_t                      q_data,
    output logic                               q_pop,
    input  logic [tlt_pkg::COLOR_W-1:0]        color,
    output logic                               vert_valid,
    output logic signed [tlt_pkg::COORD_W-1:0] vert_x,
    output logic signed [tlt_pkg::COORD_W-1:0] vert_y,
    output logic [tlt_pkg::COLOR_W-1:0]        vertex_color,
    output logic [2:0]                         vertex_index,
    output logic                               last_of_run
);
    import tlt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [QUO_W-1:0] UNIT_ONE = 31'h4000_0000;

    logic [2:0]        state_reg;
    seg_t              seg_reg;
    logic [5:0]        cnt_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  sqrem_reg;
    logic [NUM_W-1:0]  numx_reg;
    logic [NUM_W-1:0]  numy_reg;
    logic [ROOT_W:0]   remx_reg;
    logic [ROOT_W:0]   remy_reg;
    logic [QUO_W-1:0]  qx_reg;
    logic [QUO_W-1:0]  qy_reg;
    logic [47:0]       px_reg;
    logic [47:0]       py_reg;
    logic [2:0]        idx_reg;

    // Restoring square root, one root bit per cycle.
    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] rem_sh;
    logic [ROOT_W-1:0] div_s;
    logic [ROOT_W:0]  rx_sh;
    logic [ROOT_W:0]  ry_sh;
    logic [2*MAG_W-1:0] sqx;
    logic [2*MAG_W-1:0] sqy;
    logic [QUO_W-1:0] ux;
    logic [QUO_W-1:0] uy;
    logic [MAG_W-1:0] mx_w;
    logic [MAG_W-1:0] my_w;
    logic signed [COORD_W+1:0] ox;
    logic signed [COORD_W+1:0] oy;
    logic signed [COORD_W+1:0] bx;
    logic signed [COORD_W+1:0] by;

    assign sqx    = seg_reg.adx * seg_reg.adx;
    assign sqy    = seg_reg.ady * seg_reg.ady;
    assign rem_sh = {sqrem_reg[RAD_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = RAD_W'({root_reg, 2'b01});
    assign div_s  = (root_reg == '0) ? ROOT_W'(1) : root_reg;
    assign rx_sh  = {remx_reg[ROOT_W-1:0], numx_reg[NUM_W-1]};
    assign ry_sh  = {remy_reg[ROOT_W-1:0], numy_reg[NUM_W-1]};

    // Unit components are limited to one.
    assign ux = (qx_reg > UNIT_ONE) ? UNIT_ONE : qx_reg;
    assign uy = (qy_reg > UNIT_ONE) ? UNIT_ONE : qy_reg;

    // Rounded half-width offsets from the unit vector products.
    assign mx_w = MAG_W'((({16'd0, px_reg} << COORD_FRAC_BITS) + (64'd1 << 38)) >> 39);
    assign my_w = MAG_W'((({16'd0, py_reg} << COORD_FRAC_BITS) + (64'd1 << 38)) >> 39);

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vert_valid <= 1'b0;
        end
        else
        begin
            vert_valid <= state_reg == ST_EMIT;
            case (state_reg)
                ST_IDLE: if (q_valid) state_reg <= ST_SQ;
                ST_SQ:   state_reg <= ST_SQRT;
                ST_SQRT: if (cnt_reg == 6'd31) state_reg <= ST_DIV;
                ST_DIV:  if (cnt_reg == 6'd60) state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_EMIT;
                ST_EMIT: if (idx_reg == 3'd5) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath: one root bit or one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                seg_reg <= q_data;
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            ST_SQ:
            begin
                rad_reg   <= (RAD_W'(sqx) + RAD_W'(sqy)) << 14;
                root_reg  <= '0;
                sqrem_reg <= '0;
                cnt_reg   <= '0;
            end
            ST_SQRT:
            begin
                rad_reg <= rad_reg << 2;
                cnt_reg <= (cnt_reg == 6'd31) ? 6'd0 : cnt_reg + 6'd1;
                if (rem_sh >= trial)
                begin
                    sqrem_reg <= rem_sh - trial;
                    root_reg  <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sqrem_reg <= rem_sh;
                    root_reg  <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'd31)
                begin
                    numx_reg <= NUM_W'(seg_reg.adx) << 37;
                    numy_reg <= NUM_W'(seg_reg.ady) << 37;
                    remx_reg <= '0;
                    remy_reg <= '0;
                    qx_reg   <= '0;
                    qy_reg   <= '0;
                end
            end
            ST_DIV:
            begin
                cnt_reg  <= cnt_reg + 6'd1;
                numx_reg <= numx_reg << 1;
                numy_reg <= numy_reg << 1;
                if (rx_sh >= {1'b0, div_s})
                begin
                    remx_reg <= rx_sh - {1'b0, div_s};
                    qx_reg   <= {qx_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    remx_reg <= rx_sh;
                    qx_reg   <= {qx_reg[QUO_W-2:0], 1'b0};
                end
                if (ry_sh >= {1'b0, div_s})
                begin
                    remy_reg <= ry_sh - {1'b0, div_s};
                    qy_reg   <= {qy_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    remy_reg <= ry_sh;
                    qy_reg   <= {qy_reg[QUO_W-2:0], 1'b0};
                end
            end
            ST_MUL:
            begin
                px_reg <= 48'(ux) * 48'(seg_reg.w);
                py_reg <= 48'(uy) * 48'(seg_reg.w);
            end
            ST_EMIT:
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            default: ;
        endcase
    end

    // Vertex selection in the order up1, up2, dn1, dn1, up2, dn2.
    always_comb
    begin
        ox = seg_reg.dy_neg ? (COORD_W+2)'(my_w) : -((COORD_W+2)'(my_w));
        oy = seg_reg.dx_neg ? -((COORD_W+2)'(mx_w)) : (COORD_W+2)'(mx_w);
        case (idx_reg)
            3'd1, 3'd4:
            begin
                bx = (COORD_W+2)'(seg_reg.x2);
                by = (COORD_W+2)'(seg_reg.y2);
            end
            3'd5:
            begin
                bx = (COORD_W+2)'(seg_reg.x2);
                by = (COORD_W+2)'(seg_reg.y2);
                ox = -ox;
                oy = -oy;
            end
            3'd2, 3'd3:
            begin
                bx = (COORD_W+2)'(seg_reg.x1);
                by = (COORD_W+2)'(seg_reg.y1);
                ox = -ox;
                oy = -oy;
            end
            default:
            begin
                bx = (COORD_W+2)'(seg_reg.x1);
                by = (COORD_W+2)'(seg_reg.y1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            vert_x       <= sat_coord(bx + ox);
            vert_y       <= sat_coord(by + oy);
            vertex_color <= color;
            vertex_index <= idx_reg;
            last_of_run  <= idx_reg == 3'd5;
        end
    end

endmodule

// ===== rtl/core/thick_line_to_triangles.sv =====
// Channel   Direction  Handshake             Payload
// segment   in         start / busy          start_x start_y end_x end_y line_width
// vertex    out        vert_valid strobe     vert_x vert_y vertex_color vertex_index last_of_run
// config    in         cfg_valid / cfg_ready cfg_data (draw_color)
//
// Each segment passes through the back end in these steps: it is taken from the queue,
// its length is squared, a bit-serial square root runs, then a bit-serial divide
// for both unit components, one multiply and six vertex outputs. A two-entry
// queue lets the front end accept while the back end works; busy rises when
// the front register waits on a full queue. Reset clears all control state and
// sets draw_color to all ones. Vertices leave one per cycle and cannot be stalled.
module thick_line_to_triangles (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [tlt_pkg::COORD_W-1:0] start_x,
    input  logic signed [tlt_pkg::COORD_W-1:0] start_y,
    input  logic signed [tlt_pkg::COORD_W-1:0] end_x,
    input  logic signed [tlt_pkg::COORD_W-1:0] end_y,
    input  logic [tlt_pkg::WIDTH_W-1:0]        line_width,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlt_pkg::COLOR_W-1:0]        cfg_data,
    output logic                               vert_valid,
    output logic signed [tlt_pkg::COORD_W-1:0] vert_x,
    output logic signed [tlt_pkg::COORD_W-1:0] vert_y,
    output logic [tlt_pkg::COLOR_W-1:0]        vertex_color,
    output logic [2:0]                         vertex_index,
    output logic                               last_of_run
);
    import tlt_pkg::*;

    logic [COLOR_W-1:0] color_reg;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_ne;
    seg_t               q_wdata;
    seg_t               q_rdata;

    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= '1;
        else if (cfg_valid && cfg_ready)
            color_reg <= cfg_data;
    end

    tlt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .line_width(line_width), .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
    );

    tlt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .rdata(q_rdata)
    );

    tlt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_rdata), .q_pop(q_pop),
        .color(color_reg), .vert_valid(vert_valid), .vert_x(vert_x), .vert_y(vert_y),
        .vertex_color(vertex_color), .vertex_index(vertex_index),
        .last_of_run(last_of_run)
    );

`ifndef SYNTHESIS
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && last_of_run |-> vertex_index == 3'd5)
        else $error("last without index five");
    a_no_pop_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");
    a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && !last_of_run |=> vert_valid)
        else $error("vertex run broken");
`endif

endmodule

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlt_pkg::*;

    localparam int SEGMENTS_PER_PHASE = 50;
    localparam int SETTLE_CYCLES      = 300;
    localparam int STALL_LIMIT        = 20000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COLOR_W-1:0]        color;
        logic [2:0]                index;
        logic                      last;
    } vertex_t;

    // Expected vertex store with its own quad expansion predictor.
    class vertex_scoreboard;
        vertex_t expected_vertices[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe >>= 2;
            while (probe != 0)
            begin
                if (v >= root + probe)
                begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                    root >>= 1;
                probe >>= 2;
            end
            return root;
        endfunction

        function automatic longint half_width_offset(longint unsigned dmag,
                                                     longint unsigned len,
                                                     longint unsigned w);
            longint unsigned unit;
            unit = (dmag << 37) / len;
            if (unit > (64'd1 << 30))
                unit = 64'd1 << 30;
            return longint'((((unit * w) << 8) + (64'd1 << 38)) >> 39);
        endfunction

        function automatic logic signed [COORD_W-1:0] clip(longint v);
            if (v > 8388607)
                v = 8388607;
            if (v < -8388608)
                v = -8388608;
            return v[COORD_W-1:0];
        endfunction

        // Records the six vertices that one accepted segment must produce.
        function void note_segment(logic signed [COORD_W-1:0] x1,
                                   logic signed [COORD_W-1:0] y1,
                                   logic signed [COORD_W-1:0] x2,
                                   logic signed [COORD_W-1:0] y2,
                                   logic [WIDTH_W-1:0] w,
                                   logic [COLOR_W-1:0] color);
            longint dx, dy, ox, oy, mx, my;
            longint unsigned adx, ady, len;
            longint px[6], py[6];
            vertex_t v;
            dx = longint'(x2) - longint'(x1);
            dy = longint'(y2) - longint'(y1);
            if (dx == 0 && dy == 0)
                return;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            len = int_sqrt((adx * adx + ady * ady) << 14);
            if (len == 0)
                len = 1;
            mx = half_width_offset(adx, len, w);
            my = half_width_offset(ady, len, w);
            ox = (dy < 0) ? my : -my;
            oy = (dx < 0) ? -mx : mx;
            px[0] = x1 + ox; py[0] = y1 + oy;
            px[1] = x2 + ox; py[1] = y2 + oy;
            px[2] = x1 - ox; py[2] = y1 - oy;
            px[3] = px[2];   py[3] = py[2];
            px[4] = px[1];   py[4] = py[1];
            px[5] = x2 - ox; py[5] = y2 - oy;
            for (int k = 0; k < 6; k++)
            begin
                v.x     = clip(px[k]);
                v.y     = clip(py[k]);
                v.color = color;
                v.index = 3'(k);
                v.last  = (k == 5);
                expected_vertices.push_back(v);
            end
        endfunction

        // Compares one emitted vertex with the oldest expected one.
        function void check_vertex(vertex_t got);
            vertex_t exp_v;
            if (expected_vertices.size() == 0)
            begin
                $error("unexpected vertex x=%0d y=%0d index=%0d", got.x, got.y, got.index);
                errors++;
                return;
            end
            exp_v = expected_vertices.pop_front();
            if (got.x !== exp_v.x)
            begin
                $error("vert_x expected %0d actual %0d", exp_v.x, got.x);
                errors++;
            end
            if (got.y !== exp_v.y)
            begin
                $error("vert_y expected %0d actual %0d", exp_v.y, got.y);
                errors++;
            end
            if (got.color !== exp_v.color)
            begin
                $error("vertex_color expected %h actual %h", exp_v.color, got.color);
                errors++;
            end
            if (got.index !== exp_v.index)
            begin
                $error("vertex_index expected %0d actual %0d", exp_v.index, got.index);
                errors++;
            end
            if (got.last !== exp_v.last)
            begin
                $error("last_of_run expected %0d actual %0d", exp_v.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
    logic [WIDTH_W-1:0]        line_width;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [COLOR_W-1:0]        cfg_data;
    logic                      vert_valid;
    logic signed [COORD_W-1:0] vert_x, vert_y;
    logic [COLOR_W-1:0]        vertex_color;
    logic [2:0]                vertex_index;
    logic                      last_of_run;

    vertex_scoreboard  board;
    logic [COLOR_W-1:0] draw_color;
    int                idle_pct;
    int                quiet_cycles;

    thick_line_to_triangles DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .line_width   (line_width),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .vert_valid   (vert_valid),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vertex_color (vertex_color),
        .vertex_index (vertex_index),
        .last_of_run  (last_of_run)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Vertex monitor and stall watchdog.
    always @(posedge clk)
    begin
        vertex_t got;
        if (rst_n)
        begin
            if (vert_valid)
            begin
                got.x     = vert_x;
                got.y     = vert_y;
                got.color = vertex_color;
                got.index = vertex_index;
                got.last  = last_of_run;
                board.check_vertex(got);
            end
            if (vert_valid || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] clamp24(longint v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[COORD_W-1:0];
    endfunction

    // Writes the draw color through the configuration channel.
    task automatic write_color(logic [COLOR_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        draw_color = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Presents one segment and holds it until the block takes it.
    task automatic send_segment(longint x1, longint y1, longint x2, longint y2, int w);
        @(negedge clk);
        start      = 1'b1;
        start_x    = clamp24(x1);
        start_y    = clamp24(y1);
        end_x      = clamp24(x2);
        end_y      = clamp24(y2);
        line_width = w[WIDTH_W-1:0];
        do
            @(posedge clk);
        while (busy);
        board.note_segment(start_x, start_y, end_x, end_y, line_width, draw_color);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // Waits until every expected vertex has arrived, then lets the block settle.
    task automatic drain_block();
        @(negedge clk);
        start = 1'b0;
        while (board.expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_segment();
        longint x1, y1, span;
        int kind;
        kind = $urandom_range(99);
        x1 = longint'($signed(24'($urandom)));
        y1 = longint'($signed(24'($urandom)));
        if (kind < 5)
            send_segment(x1, y1, x1, y1, $urandom_range(65535));
        else if (kind < 20)
            send_segment(x1, y1, longint'($signed(24'($urandom))),
                         longint'($signed(24'($urandom))), $urandom_range(65535));
        else
        begin
            span = (kind < 60) ? 4096 : 262144;
            send_segment(x1, y1,
                         x1 + longint'($urandom_range(2 * span)) - span,
                         y1 + longint'($urandom_range(2 * span)) - span,
                         (kind < 90) ? $urandom_range(4096) : $urandom_range(65535));
        end
    endtask

    initial
    begin
        int idle_plan[4];
        logic [COLOR_W-1:0] color_plan[4];
        board        = new();
        draw_color   = '1;
        quiet_cycles = 0;
        idle_pct     = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        start_x      = '0;
        start_y      = '0;
        end_x        = '0;
        end_y        = '0;
        line_width   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        idle_plan    = '{0, 52, 13, 0};
        color_plan   = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed segments with the reset color.
        send_segment(0, 0, 256, 0, 256);
        send_segment(0, 0, 0, 256, 256);
        send_segment(256, 256, 0, 0, 512);
        send_segment(0, 256, 0, 0, 512);
        send_segment(100, 100, 100, 100, 256);
        send_segment(-8388608, -8388608, 8388607, 8388607, 65535);
        send_segment(8388607, 8388607, -8388608, -8388608, 65535);
        send_segment(-8388608, 8388607, 8388607, -8388608, 1);
        send_segment(0, 0, 1000, 700, 0);
        send_segment(8388607, 0, 8388607, 1000, 65535);
        send_segment(-8388608, 0, -8388608, -1000, 65535);
        send_segment(0, 8388607, 1000, 8388607, 65535);
        send_segment(0, -8388608, -1000, -8388608, 65535);
        send_segment(0, 0, 1, 0, 65535);
        send_segment(0, 0, 1, 1, 65535);
        send_segment(0, 0, -1, 1, 3);
        send_segment(5, 5, 5, 5, 0);
        send_segment(-3000, 2000, 4000, -1500, 777);
        drain_block();

        // Random phases, each under its own color and sender idling.
        for (int p = 0; p < 4; p++)
        begin
            write_color(color_plan[p]);
            idle_pct = idle_plan[p];
            for (int i = 0; i < SEGMENTS_PER_PHASE; i++)
                random_segment();
            drain_block();
        end

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
